// ===== design/fbl_pkg.sv =====
// Shared types and constants for the first-fit free-block list.
package fbl_pkg;

  localparam int ENTRIES    = 64;
  localparam int WORD_BYTES = 8;
  localparam int SW         = $clog2(ENTRIES);
  localparam int LW         = SW + 1;
  localparam int AW         = 48;
  localparam int ZW         = 32;
  localparam int TW         = 40;

  localparam logic [LW-1:0] EMPTY = LW'(ENTRIES);

  localparam logic [2:0] FN_FREE      = 3'd0;
  localparam logic [2:0] FN_OBT_SMALL = 3'd1;
  localparam logic [2:0] FN_OBT_LARGE = 3'd2;
  localparam logic [2:0] FN_LK_SMALL  = 3'd3;
  localparam logic [2:0] FN_LK_LARGE  = 3'd4;
  localparam logic [2:0] FN_REBUILD   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]    func;
    logic [AW-1:0] block_addr;
    logic [ZW-1:0] size_bytes;
  } fbl_in_t;

  typedef struct packed {
    logic          found;
    logic [AW-1:0] out_addr;
    logic [ZW-1:0] out_size;
    logic [TW-1:0] total_avail;
    logic [ZW-1:0] max_hint;
    logic [1:0]    status;
  } fbl_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SPARE,
    S_WALK,
    S_EMIT
  } fsm_t;

  typedef struct packed {
    logic       load;
    logic       rd_stack;
    logic       free_fresh;
    logic       free_stack;
    logic       rd_head;
    logic       step;
    logic       unlink;
    logic       hint_lower;
    logic       rebuild;
    logic       res_set;
    logic       res_found;
    logic [1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       spare_ok;
    logic       stk_ok;
    logic       head_ok;
    logic       fits;
    logic       link_ok;
    logic       walk_last;
    logic       over_total;
  } dp_stat_t;

endpackage

// ===== design/fbl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fbl_ctrl.sv =====
// Sequencer for the free-block list: decodes the beat and drives the datapath.
module fbl_ctrl
  import fbl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  fsm_t state_r, state_nxt;
  logic obtain, big_req;

  assign obtain  = (stat.func == FN_OBT_SMALL) || (stat.func == FN_OBT_LARGE);
  assign big_req = (stat.func == FN_OBT_LARGE) || (stat.func == FN_LK_LARGE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_DISP;
      S_DISP: begin
        priority if (stat.func == FN_FREE && stat.spare_ok && stat.stk_ok) state_nxt = S_SPARE;
        else if ((stat.func == FN_OBT_SMALL || stat.func == FN_LK_SMALL) && stat.head_ok)
          state_nxt = S_WALK;
        else if (big_req && stat.head_ok && !(stat.func == FN_LK_LARGE && stat.over_total))
          state_nxt = S_WALK;
        else state_nxt = S_EMIT;
      end
      S_SPARE: state_nxt = S_EMIT;
      S_WALK: begin
        if (stat.fits || !big_req || !stat.link_ok || stat.walk_last) state_nxt = S_EMIT;
      end
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_status = ST_OK;
    unique case (state_r)
      S_IDLE: cmd.load = start;
      S_DISP: begin
        unique case (stat.func)
          FN_FREE: begin
            if (!stat.spare_ok) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_FULL;
            end else if (stat.stk_ok) begin
              cmd.rd_stack = 1'b1;
            end else begin
              cmd.free_fresh = 1'b1;
              cmd.res_set    = 1'b1;
            end
          end
          FN_OBT_SMALL, FN_LK_SMALL: begin
            if (stat.head_ok) begin
              cmd.rd_head = 1'b1;
            end else begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOFIT;
            end
          end
          FN_OBT_LARGE, FN_LK_LARGE: begin
            if (stat.func == FN_LK_LARGE && stat.over_total) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOFIT;
            end else if (stat.head_ok) begin
              cmd.rd_head = 1'b1;
            end else begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOFIT;
              cmd.hint_lower = (stat.func == FN_OBT_LARGE);
            end
          end
          FN_REBUILD: begin
            cmd.rebuild = 1'b1;
            cmd.res_set = 1'b1;
          end
          default: cmd.res_set = 1'b1;
        endcase
      end
      S_SPARE: begin
        cmd.free_stack = 1'b1;
        cmd.res_set    = 1'b1;
      end
      S_WALK: begin
        if (stat.fits) begin
          cmd.res_set   = 1'b1;
          cmd.res_found = 1'b1;
          cmd.unlink    = obtain;
        end else if (big_req && stat.link_ok && !stat.walk_last) begin
          cmd.step = 1'b1;
        end else begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOFIT;
          cmd.hint_lower = (stat.func == FN_OBT_LARGE);
        end
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);

endmodule

// ===== design/fbl_dp.sv =====
// Datapath: descriptor and spare-slot memories, list head, totals and result.
module fbl_dp
  import fbl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  fbl_in_t  in_item,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output fbl_out_t out_item
);

  fbl_in_t        req_r;
  logic [LW-1:0]  head_r, cur_r, prev_r, stk_cnt_r, fresh_r;
  logic [SW-1:0]  steps_r;
  logic [TW-1:0]  total_r;
  logic [ZW-1:0]  hint_r;
  logic           found_r;
  logic [AW-1:0]  raddr_r;
  logic [ZW-1:0]  rsize_r;
  logic [1:0]     status_r;

  logic [AW+ZW-1:0] desc_rd;
  logic [LW-1:0]    link_rd;
  logic [SW-1:0]    stk_rd;
  logic [SW-1:0]    rd_addr, new_slot;
  logic             free_wr, prev_ok, link_we, stk_we;
  logic [SW-1:0]    link_waddr;
  logic [LW-1:0]    link_wdata;
  logic [TW:0]      sum;
  logic [ZW-1:0]    cur_size, lim;

  assign cur_size   = desc_rd[ZW-1:0];
  assign free_wr    = cmd.free_fresh || cmd.free_stack;
  assign new_slot   = cmd.free_stack ? stk_rd : fresh_r[SW-1:0];
  assign rd_addr    = cmd.step ? link_rd[SW-1:0] : head_r[SW-1:0];
  assign prev_ok    = (prev_r < EMPTY);
  assign link_we    = free_wr || (cmd.unlink && prev_ok);
  assign link_waddr = free_wr ? new_slot : prev_r[SW-1:0];
  assign link_wdata = free_wr ? head_r : link_rd;
  assign stk_we     = cmd.unlink && (stk_cnt_r < EMPTY);
  assign sum        = {1'b0, total_r} + (TW+1)'(req_r.size_bytes);
  assign lim        = (req_r.size_bytes > ZW'(WORD_BYTES)) ?
                      req_r.size_bytes - ZW'(WORD_BYTES) : '0;

  fbl_ram #(.WIDTH(AW+ZW), .DEPTH(ENTRIES)) u_desc (
    .clk(clk), .we(free_wr), .waddr(new_slot),
    .wdata({req_r.block_addr, req_r.size_bytes}),
    .raddr(rd_addr), .rdata(desc_rd)
  );

  fbl_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(rd_addr), .rdata(link_rd)
  );

  fbl_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_spare (
    .clk(clk), .we(stk_we), .waddr(stk_cnt_r[SW-1:0]), .wdata(cur_r[SW-1:0]),
    .raddr(SW'(stk_cnt_r - LW'(1))), .rdata(stk_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= EMPTY;
      stk_cnt_r <= '0;
      fresh_r   <= '0;
      total_r   <= '0;
      hint_r    <= '0;
    end else begin
      if (free_wr) begin
        head_r  <= {1'b0, new_slot};
        total_r <= sum[TW] ? '1 : sum[TW-1:0];
        if (req_r.size_bytes > hint_r) hint_r <= req_r.size_bytes;
      end
      if (cmd.free_fresh) fresh_r <= fresh_r + LW'(1);
      if (cmd.free_stack) stk_cnt_r <= stk_cnt_r - LW'(1);
      if (cmd.unlink) begin
        if (!prev_ok) head_r <= link_rd;
        total_r <= (total_r >= TW'(cur_size)) ? total_r - TW'(cur_size) : '0;
        if (stk_we) stk_cnt_r <= stk_cnt_r + LW'(1);
      end
      if (cmd.hint_lower && lim < hint_r) hint_r <= lim;
      if (cmd.rebuild) begin
        head_r    <= EMPTY;
        stk_cnt_r <= '0;
        fresh_r   <= '0;
        total_r   <= '0;
        hint_r    <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_item;
    if (cmd.rd_head) begin
      cur_r   <= head_r;
      prev_r  <= EMPTY;
      steps_r <= '0;
    end
    if (cmd.step) begin
      prev_r  <= cur_r;
      cur_r   <= link_rd;
      steps_r <= steps_r + SW'(1);
    end
    if (cmd.res_set) begin
      found_r  <= cmd.res_found;
      raddr_r  <= cmd.res_found ? desc_rd[AW+ZW-1:ZW] : '0;
      rsize_r  <= cmd.res_found ? cur_size : '0;
      status_r <= cmd.res_status;
    end
  end

  assign stat.func       = req_r.func;
  assign stat.spare_ok   = (stk_cnt_r != '0) || (fresh_r != EMPTY);
  assign stat.stk_ok     = (stk_cnt_r != '0);
  assign stat.head_ok    = (head_r < EMPTY);
  assign stat.fits       = (cur_size >= req_r.size_bytes);
  assign stat.link_ok    = (link_rd < EMPTY);
  assign stat.walk_last  = (steps_r == SW'(ENTRIES - 1));
  assign stat.over_total = (TW'(req_r.size_bytes) > total_r);

  assign out_item.found       = found_r;
  assign out_item.out_addr    = raddr_r;
  assign out_item.out_size    = rsize_r;
  assign out_item.total_avail = total_r;
  assign out_item.max_hint    = hint_r;
  assign out_item.status      = status_r;

endmodule

// ===== design/free_block_list_first_fit_top.sv =====
// Top level of the first-fit free-block list: sequencer plus datapath.
//
//  channel   ports                      beat taken when
//  input     start, busy, in_item       start high and busy low at the edge
//  result    out_valid, out_item        out_valid high, one cycle, no stall
//
// A free takes a recycled slot from the spare stack when there is one; a small
// obtain or lookup reads only the head descriptor; a large obtain or lookup
// walks the chain from the head, up to 64 descriptors, and walks none on an
// empty list or when a large lookup asks for more than the total.
// The walk reads one descriptor per cycle from the registered descriptor and
// link RAMs.
// Reset is synchronous; it empties the list and marks every slot unused,
// with no clearing pass. Results cannot be held off by the receiver.
module free_block_list_first_fit_top
  import fbl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  fbl_in_t  in_item,
  output logic     out_valid,
  output fbl_out_t out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  fbl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .stat(stat), .cmd(cmd)
  );

  // memories, head, total, hint and result registers
  fbl_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd),
    .stat(stat), .out_item(out_item)
  );

endmodule

// ===== tb/sv/tb_free_block_list_first_fit_top.sv =====
// Testbench for the first-fit free-block list: directed table, then random commands.
`timescale 1ns / 100ps

module tb_free_block_list_first_fit_top;
  import fbl_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM    = 1400;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  fbl_in_t  in_item = '0;
  logic     out_valid;
  fbl_out_t out_item;

  always #5 clk = ~clk;

  free_block_list_first_fit_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // Predictor state: a copy of the descriptor table, chain and spare stack.
  logic [AW-1:0] blk_addr [ENTRIES];
  logic [ZW-1:0] blk_size [ENTRIES];
  logic [LW-1:0] blk_link [ENTRIES];
  logic [LW-1:0] head;
  logic [SW-1:0] spare [ENTRIES];
  int            n_spare;
  logic [TW-1:0] total;
  logic [ZW-1:0] hint;

  fbl_out_t pending_results[$];
  int       mismatches = 0;
  int       idle_cycles = 0;

  function automatic void list_reset();
    for (int i = 0; i < ENTRIES; i++) spare[i] = SW'(ENTRIES - 1 - i);
    head = EMPTY; n_spare = ENTRIES; total = '0; hint = '0;
  endfunction

  // Remove slot s from the chain (prev == EMPTY means s is the head).
  function automatic void drop_slot(logic [LW-1:0] s, logic [LW-1:0] prev);
    if (prev != EMPTY) blk_link[prev[SW-1:0]] = blk_link[s[SW-1:0]];
    else head = blk_link[s[SW-1:0]];
    blk_link[s[SW-1:0]] = EMPTY;
    total = (total >= TW'(blk_size[s[SW-1:0]])) ? total - TW'(blk_size[s[SW-1:0]]) : '0;
    if (n_spare < ENTRIES) spare[n_spare++] = s[SW-1:0];
  endfunction

  function automatic fbl_out_t list_step(fbl_in_t c);
    fbl_out_t r;
    logic [LW-1:0] s, prev, cur;
    logic [TW:0] sum;
    int steps;
    r = '0;
    case (c.func)
      FN_FREE: begin
        if (n_spare == 0) begin
          r.status = ST_FULL;
        end else begin
          s = LW'(spare[--n_spare]);
          blk_addr[s[SW-1:0]] = c.block_addr;
          blk_size[s[SW-1:0]] = c.size_bytes;
          blk_link[s[SW-1:0]] = head;
          head = s;
          sum = {1'b0, total} + (TW+1)'(c.size_bytes);
          total = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
          if (c.size_bytes > hint) hint = c.size_bytes;
        end
      end
      FN_OBT_SMALL, FN_LK_SMALL: begin
        if (head != EMPTY && blk_size[head[SW-1:0]] >= c.size_bytes) begin
          r.found = 1'b1;
          r.out_addr = blk_addr[head[SW-1:0]];
          r.out_size = blk_size[head[SW-1:0]];
          if (c.func == FN_OBT_SMALL) drop_slot(head, EMPTY);
        end else begin
          r.status = ST_NOFIT;
        end
      end
      FN_OBT_LARGE, FN_LK_LARGE: begin
        if (c.func == FN_LK_LARGE && TW'(c.size_bytes) > total) begin
          r.status = ST_NOFIT;
        end else begin
          cur = head; prev = EMPTY; s = EMPTY; steps = 0;
          while (cur != EMPTY && steps < ENTRIES && s == EMPTY) begin
            if (blk_size[cur[SW-1:0]] >= c.size_bytes) begin
              s = cur;
            end else begin
              prev = cur; cur = blk_link[cur[SW-1:0]]; steps++;
            end
          end
          if (s != EMPTY) begin
            r.found = 1'b1;
            r.out_addr = blk_addr[s[SW-1:0]];
            r.out_size = blk_size[s[SW-1:0]];
            if (c.func == FN_OBT_LARGE) drop_slot(s, prev);
          end else begin
            r.status = ST_NOFIT;
            if (c.func == FN_OBT_LARGE) begin
              // hint drops to request less a word, floored at zero
              if (c.size_bytes > ZW'(WORD_BYTES)) begin
                if (c.size_bytes - ZW'(WORD_BYTES) < hint) hint = c.size_bytes - ZW'(WORD_BYTES);
              end else begin
                hint = '0;
              end
            end
          end
        end
      end
      FN_REBUILD: begin
        cur = head; steps = 0;
        while (cur != EMPTY && steps < ENTRIES) begin
          if (n_spare < ENTRIES) spare[n_spare++] = cur[SW-1:0];
          cur = blk_link[cur[SW-1:0]]; steps++;
        end
        head = EMPTY; total = '0; hint = '0;
      end
      default: ;
    endcase
    r.total_avail = total;
    r.max_hint = hint;
    return r;
  endfunction

  // Directed table; typed expectations only where they are obvious.
  typedef struct {
    fbl_in_t  cmd;
    bit       typed;
    fbl_out_t want;
  } row_t;

  row_t rows[$];

  function automatic fbl_out_t res(bit f, logic [AW-1:0] a, logic [ZW-1:0] z,
                                   logic [TW-1:0] t, logic [ZW-1:0] h, logic [1:0] st);
    fbl_out_t r;
    r.found = f; r.out_addr = a; r.out_size = z;
    r.total_avail = t; r.max_hint = h; r.status = st;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] f, logic [AW-1:0] a, logic [ZW-1:0] z,
                                  bit typed = 0, fbl_out_t w = '0);
    row_t r;
    r.cmd.func = f; r.cmd.block_addr = a; r.cmd.size_bytes = z;
    r.typed = typed; r.want = w;
    rows.push_back(r);
  endfunction

  function automatic void build_table();
    // empty list: every search misses
    add_row(FN_OBT_SMALL, '0, '0, 1, res(0, 0, 0, 0, 0, ST_NOFIT));
    add_row(FN_OBT_LARGE, '0, 32'd4, 1, res(0, 0, 0, 0, 0, ST_NOFIT));
    add_row(FN_LK_LARGE, '0, 32'd1, 1, res(0, 0, 0, 0, 0, ST_NOFIT));
    add_row(3'd6, '1, '1, 1, res(0, 0, 0, 0, 0, ST_OK));
    add_row(3'd7, '1, '1, 1, res(0, 0, 0, 0, 0, ST_OK));
    add_row(FN_FREE, '1, '1, 1, res(0, 0, 0, 40'h00_FFFF_FFFF, '1, ST_OK));
    add_row(FN_FREE, 48'h1000, '0);
    add_row(FN_FREE, 48'h2000, 32'd100);
    add_row(FN_FREE, 48'h3000, 32'd20);
    add_row(FN_LK_SMALL, '0, 32'd20);
    add_row(FN_OBT_SMALL, '0, 32'd21);
    add_row(FN_LK_LARGE, '0, 32'd50);
    add_row(FN_OBT_LARGE, '0, 32'd50);
    add_row(FN_OBT_LARGE, '0, 32'd0);
    add_row(FN_OBT_LARGE, '0, 32'd5);   // hit past the head with request below a word
    add_row(FN_LK_LARGE, '0, '1);       // above total
    add_row(FN_REBUILD, '0, '0, 1, res(0, 0, 0, 0, 0, ST_OK));
    // fill the table past its depth
    for (int i = 0; i < ENTRIES; i++) add_row(FN_FREE, AW'(i * 64), ZW'(i * 3 + 1));
    add_row(FN_FREE, 48'hABC, 32'd7);   // full
    add_row(FN_OBT_LARGE, '0, 32'd2);   // hit at the head
    add_row(FN_OBT_LARGE, '0, 32'd300); // miss after walking all
    add_row(FN_REBUILD, '0, '0, 1, res(0, 0, 0, 0, 0, ST_OK));
  endfunction

  // start stays high until the caller idles or drives the next beat
  task automatic send(fbl_in_t c);
    start   <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(list_step(c));
  endtask

  task automatic gap(bit calm);
    if (!calm && $urandom_range(99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic fbl_in_t rand_cmd();
    fbl_in_t c;
    int pick;
    c.block_addr = AW'({$urandom, $urandom});
    pick = $urandom_range(99);
    // sizes mostly small so searches hit and miss; a few extremes
    case ($urandom_range(9))
      0:       c.size_bytes = $urandom;
      1:       c.size_bytes = '1;
      2:       c.size_bytes = $urandom_range(8);
      default: c.size_bytes = $urandom_range(600);
    endcase
    if (pick < 40)      c.func = FN_FREE;
    else if (pick < 50) c.func = FN_OBT_SMALL;
    else if (pick < 70) c.func = FN_OBT_LARGE;
    else if (pick < 78) c.func = FN_LK_SMALL;
    else if (pick < 94) c.func = FN_LK_LARGE;
    else if (pick < 97) c.func = FN_REBUILD;
    else                c.func = 3'($urandom_range(6, 7));
    return c;
  endfunction

  // Results: compare each strobe against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_item);
      end else begin
        fbl_out_t w;
        w = pending_results.pop_front();
        if (out_item !== w) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", w, out_item);
        end
      end
    end
  end

  // Watchdog on cycles with no beat in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    fbl_in_t c;
    list_reset();
    build_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      c = rows[i].cmd;
      send(c);
      if (rows[i].typed && pending_results[$] !== rows[i].want) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d: predictor %p, table %p",
                                       i, pending_results[$], rows[i].want);
      end
      gap(0);
    end
    start <= 1'b0;
    // hold off until every predicted result has been checked
    wait (pending_results.size() == 0);
    @(posedge clk);
    for (int n = 0; n < N_RANDOM; n++) begin
      send(rand_cmd());
      gap(n > 500 && n < 700);
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fbl_pkg.sv
design/fbl_ram.sv
design/fbl_ctrl.sv
design/fbl_dp.sv
design/free_block_list_first_fit_top.sv
tb/sv/tb_free_block_list_first_fit_top.sv
